// File: src/g2e_pkg.sv
// ----------------------------------------------------------------------------
// g2e_pkg
// Types, constants and elaboration-time table functions shared by the
// geodetic to earth-centred conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package g2e_pkg;

	localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;
	localparam logic [63:0] INV_SQRT2_Q62 = 64'h2D413CCCFE779921;
	localparam int          RADIUS_FRAC   = 16;
	localparam logic [63:0] OUT_LIMIT     = 64'd120000000000;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 42;
	localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FLAT   = 2'd1;

	localparam logic [33:0] SEMI_MAJOR_RESET = 34'd6378137000;
	localparam logic [41:0] INV_FLAT_RESET   = 42'd1281005021000;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	typedef struct packed {
		logic [1:0]         quad_lat;
		logic [29:0]        resid_lat;
		logic [1:0]         quad_lon;
		logic [29:0]        resid_lon;
		logic signed [37:0] altitude;
	} g2e_item_t;

	typedef enum logic [2:0] {
		ECC_IDLE,
		ECC_DIV,
		ECC_SQA,
		ECC_SQB,
		ECC_DONE
	} ecc_state_t;

	function automatic logic [63:0] atan_q62(input int j);
		logic [63:0] acc;
		logic [63:0] term;
		int kk;
		acc = '0;
		if (j == 0) begin
			acc = PI_Q60;
		end else begin
			for (kk = 1; j * kk <= 62; kk += 2) begin
				term = (64'd1 << (62 - j * kk)) / 64'(kk);
				if (((kk >> 1) & 1) == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] gain_q62(input int steps);
		logic [63:0]  g;
		logic [63:0]  fac;
		logic [63:0]  term;
		logic [127:0] prod;
		int j;
		int nn;
		g = INV_SQRT2_Q62;
		for (j = 1; j < steps; j++) begin
			fac = 64'd1 << 62;
			if (2 * j <= 62) begin
				term = 64'd1 << 62;
				nn = 1;
				while (term != 64'd0) begin
					term = ((term >> (2 * j)) * 64'(2 * nn - 1)) / 64'(2 * nn);
					if ((nn & 1) == 1) begin
						fac = fac - term;
					end else begin
						fac = fac + term;
					end
					nn++;
				end
			end
			prod = {64'd0, g} * {64'd0, fac} + (128'd1 << 61);
			g = prod[125:62];
		end
		return g;
	endfunction

	function automatic logic [63:0] q62_to_frac(input logic [63:0] v, input int f);
		return (v + (64'd1 << (61 - f))) >> (62 - f);
	endfunction

	function automatic logic [47:0] ecc_of(input logic [41:0] inv);
		logic [63:0]  iv;
		logic [63:0]  rem;
		logic [127:0] quo;
		logic [63:0]  flat;
		logic [127:0] prod;
		logic [63:0]  ecc;
		int i;
		iv = {22'd0, inv};
		if (iv < (64'd1 << 32)) begin
			iv = 64'd1 << 32;
		end
		rem = '0;
		quo = '0;
		for (i = 80; i >= 0; i--) begin
			rem = {rem[62:0], (i == 80) ? 1'b1 : 1'b0};
			quo = {quo[126:0], 1'b0};
			if (rem >= iv) begin
				rem    = rem - iv;
				quo[0] = 1'b1;
			end
		end
		flat = (quo > (128'd1 << 48)) ? (64'd1 << 48) : quo[63:0];
		prod = {64'd0, flat} * {64'd0, flat} + (128'd1 << 47);
		ecc = (flat << 1) - prod[111:48];
		if (ecc > ((64'd1 << 48) - 64'd1)) begin
			ecc = (64'd1 << 48) - 64'd1;
		end
		return ecc[47:0];
	endfunction

	localparam logic [47:0] ECC_RESET = ecc_of(INV_FLAT_RESET);

	function automatic logic [37:0] saturate(input logic [63:0] v);
		logic [63:0] mag;
		logic [63:0] res;
		mag = v[63] ? (64'd0 - v) : v;
		if (mag > OUT_LIMIT) begin
			mag = OUT_LIMIT;
		end
		res = v[63] ? (64'd0 - mag) : mag;
		return res[37:0];
	endfunction

endpackage

`default_nettype wire

// File: src/g2e_mul.sv
// ----------------------------------------------------------------------------
// g2e_mul
// Two-stage 64 by 64 multiplier built from four 32 by 32 partial products,
// with rounding, a fixed right shift and optional sign-magnitude handling.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_mul #(
	parameter int SHIFT  = 48,
	parameter bit SIGNED = 1'b0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic      [63:0] p
);
	localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

	logic         neg;
	logic [63:0]  ma;
	logic [63:0]  mb;
	logic [63:0]  pp_ll_s1;
	logic [63:0]  pp_lh_s1;
	logic [63:0]  pp_hl_s1;
	logic [63:0]  pp_hh_s1;
	logic         neg_s1;
	logic [127:0] sum;
	logic [127:0] shifted;
	logic [63:0]  res;
	logic [63:0]  p_s2;

	assign neg = SIGNED ? (a[63] ^ b[63]) : 1'b0;
	assign ma  = (SIGNED && a[63]) ? (64'd0 - a) : a;
	assign mb  = (SIGNED && b[63]) ? (64'd0 - b) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
			pp_lh_s1 <= {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
			pp_hl_s1 <= {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
			pp_hh_s1 <= {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
			neg_s1   <= neg;
		end
	end

	assign sum = {pp_hh_s1, 64'd0} + {32'd0, pp_lh_s1, 32'd0} + {32'd0, pp_hl_s1, 32'd0}
		+ {64'd0, pp_ll_s1} + RND;
	assign shifted = sum >> SHIFT;
	assign res = shifted[63:0];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= neg_s1 ? (64'd0 - res) : res;
		end
	end

	assign p = p_s2;
endmodule

`default_nettype wire

// File: src/g2e_dly.sv
// ----------------------------------------------------------------------------
// g2e_dly
// Enabled delay line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	logic [W-1:0] dl_s [0:N-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				dl_s[i] <= dl_s[i-1];
			end
		end
	end

	assign q = dl_s[N-1];
endmodule

`default_nettype wire

// File: src/g2e_cordic.sv
// ----------------------------------------------------------------------------
// g2e_cordic
// Pipelined rotation-mode CORDIC, one stage per step, followed by a quadrant
// fold that yields cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_cordic #(
	parameter int STEPS = 32,
	parameter int F     = 48
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] zr,
	input  wire logic [1:0]  quad,
	output logic      [63:0] cosv,
	output logic      [63:0] sinv
);
	import g2e_pkg::*;

	localparam logic [63:0] GAIN = q62_to_frac(gain_q62(STEPS), F);

	logic [63:0] x_s [0:STEPS-1];
	logic [63:0] y_s [0:STEPS-1];
	logic [63:0] z_s [0:STEPS-1];
	logic [1:0]  q_s [0:STEPS-1];
	logic [63:0] cos_s;
	logic [63:0] sin_s;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [63:0] ATAN_J = q62_to_frac(atan_q62(j), F);
		logic [63:0] xi;
		logic [63:0] yi;
		logic [63:0] zi;
		logic [1:0]  qi;
		logic [63:0] dx;
		logic [63:0] dy;
		if (j == 0) begin : g_first
			assign xi = GAIN;
			assign yi = '0;
			assign zi = zr;
			assign qi = quad;
		end else begin : g_next
			assign xi = x_s[j-1];
			assign yi = y_s[j-1];
			assign zi = z_s[j-1];
			assign qi = q_s[j-1];
		end
		assign dx = 64'($signed(yi) >>> j);
		assign dy = 64'($signed(xi) >>> j);
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi[63]) begin
					x_s[j] <= xi + dx;
					y_s[j] <= yi - dy;
					z_s[j] <= zi + ATAN_J;
				end else begin
					x_s[j] <= xi - dx;
					y_s[j] <= yi + dy;
					z_s[j] <= zi - ATAN_J;
				end
				q_s[j] <= qi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[STEPS-1])
				QUAD_0: begin
					cos_s <= x_s[STEPS-1];
					sin_s <= y_s[STEPS-1];
				end
				QUAD_1: begin
					cos_s <= 64'd0 - y_s[STEPS-1];
					sin_s <= x_s[STEPS-1];
				end
				QUAD_2: begin
					cos_s <= 64'd0 - x_s[STEPS-1];
					sin_s <= 64'd0 - y_s[STEPS-1];
				end
				default: begin
					cos_s <= y_s[STEPS-1];
					sin_s <= 64'd0 - x_s[STEPS-1];
				end
			endcase
		end
	end

	assign cosv = cos_s;
	assign sinv = sin_s;
endmodule

`default_nettype wire

// File: src/g2e_ecc.sv
// ----------------------------------------------------------------------------
// g2e_ecc
// Sequencer that derives eccentricity squared from the inverse flattening:
// a bit-serial divide followed by one squaring on its own multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_ecc (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [41:0] inv_data,
	output logic             busy,
	output logic      [47:0] ecc
);
	import g2e_pkg::*;

	ecc_state_t  state_q;
	ecc_state_t  state_d;
	logic [41:0] inv_q;
	logic [41:0] rem_q;
	logic [48:0] flat_q;
	logic [5:0]  cnt_q;
	logic [47:0] ecc_q;
	logic [42:0] rem2;
	logic        take;
	logic [63:0] sq;
	logic [63:0] ecc_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ECC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ECC_IDLE: begin
				if (start) begin
					state_d = ECC_DIV;
				end
			end
			ECC_DIV: begin
				if (cnt_q == 6'd0) begin
					state_d = ECC_SQA;
				end
			end
			ECC_SQA:  state_d = ECC_SQB;
			ECC_SQB:  state_d = ECC_DONE;
			ECC_DONE: state_d = ECC_IDLE;
			default:  state_d = ECC_IDLE;
		endcase
	end

	assign busy = (state_q != ECC_IDLE);
	assign rem2 = {rem_q, 1'b0};
	assign take = (rem2 >= {1'b0, inv_q});

	always_ff @(posedge clk) begin
		if (state_q == ECC_IDLE && start) begin
			inv_q  <= (inv_data < (42'd1 << 32)) ? (42'd1 << 32) : inv_data;
			rem_q  <= 42'd1 << 31;
			flat_q <= '0;
			cnt_q  <= 6'd48;
		end else if (state_q == ECC_DIV) begin
			rem_q  <= take ? 42'(rem2 - {1'b0, inv_q}) : rem2[41:0];
			flat_q <= {flat_q[47:0], take};
			cnt_q  <= cnt_q - 6'd1;
		end
	end

	g2e_mul #(.SHIFT(48), .SIGNED(1'b0)) u_sq (
		.clk (clk),
		.en  (1'b1),
		.a   ({15'd0, flat_q}),
		.b   ({15'd0, flat_q}),
		.p   (sq)
	);

	assign ecc_full = {14'd0, flat_q, 1'b0} - sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q <= ECC_RESET;
		end else if (state_q == ECC_DONE) begin
			ecc_q <= (ecc_full > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : ecc_full[47:0];
		end
	end

	assign ecc = ecc_q;
endmodule

`default_nettype wire

// File: src/g2e_front.sv
// ----------------------------------------------------------------------------
// g2e_front
// Input side: takes points, splits each angle into quadrant and residue, and
// queues them for the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] latitude,
	input  wire logic signed [31:0] longitude,
	input  wire logic signed [37:0] altitude,
	input  wire logic               hold,
	input  wire logic               pop,
	output logic                    avail,
	output g2e_pkg::g2e_item_t      item
);
	import g2e_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	g2e_item_t   fifo_q [0:DEPTH-1];
	g2e_item_t   wr_item;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push;

	assign in_stall = (count_q == (PW+1)'(DEPTH)) || hold;
	assign push     = in_valid && !in_stall;
	assign avail    = (count_q != '0);
	assign item     = fifo_q[rd_ptr_q];

	assign wr_item.quad_lat  = latitude[31:30];
	assign wr_item.resid_lat = latitude[29:0];
	assign wr_item.quad_lon  = longitude[31:30];
	assign wr_item.resid_lon = longitude[29:0];
	assign wr_item.altitude  = altitude;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

`default_nettype wire

// File: src/g2e_back.sv
// ----------------------------------------------------------------------------
// g2e_back
// Arithmetic pipeline: sine and cosine, prime vertical radius through a
// digit-recurrence square root and divide, the final products and output
// saturation. The whole pipeline advances together unless the result holds.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_back #(
	parameter int STEPS = 32,
	parameter int F     = 48
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               avail,
	input  g2e_pkg::g2e_item_t      item,
	input  wire logic [33:0]        a_axis,
	input  wire logic [47:0]        ecc,
	input  wire logic               out_stall,
	output logic                    pop,
	output logic                    out_valid,
	output logic signed [37:0]      ecef_x,
	output logic signed [37:0]      ecef_y,
	output logic signed [37:0]      ecef_z
);
	import g2e_pkg::*;

	localparam int NB   = F + 1;
	localparam int QB   = 57;
	localparam int NW   = F + 50;
	localparam int C    = STEPS + 3;
	localparam int R    = C + F + 6;
	localparam int D    = R + QB + 2;
	localparam int LAST = D + 6;
	localparam logic [63:0] ONE = 64'd1 << F;

	logic            en;
	logic [LAST:0]   vld_q;
	g2e_item_t       item_s0;

	assign en  = !(vld_q[LAST] && out_stall);
	assign pop = en && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-1:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s0 <= item;
		end
	end

	logic [63:0] zr_lat;
	logic [63:0] zr_lon;
	logic [3:0]  quad_d;
	logic [63:0] clat;
	logic [63:0] slat;
	logic [63:0] clon;
	logic [63:0] slon;

	g2e_mul #(.SHIFT(91 - F), .SIGNED(1'b0)) u_zlat (
		.clk (clk), .en (en), .a ({34'd0, item_s0.resid_lat}), .b (PI_Q60), .p (zr_lat)
	);
	g2e_mul #(.SHIFT(91 - F), .SIGNED(1'b0)) u_zlon (
		.clk (clk), .en (en), .a ({34'd0, item_s0.resid_lon}), .b (PI_Q60), .p (zr_lon)
	);
	g2e_dly #(.W(4), .N(2)) u_quad (
		.clk (clk), .en (en), .d ({item_s0.quad_lat, item_s0.quad_lon}), .q (quad_d)
	);
	g2e_cordic #(.STEPS(STEPS), .F(F)) u_cord_lat (
		.clk (clk), .en (en), .zr (zr_lat), .quad (quad_d[3:2]), .cosv (clat), .sinv (slat)
	);
	g2e_cordic #(.STEPS(STEPS), .F(F)) u_cord_lon (
		.clk (clk), .en (en), .zr (zr_lon), .quad (quad_d[1:0]), .cosv (clon), .sinv (slon)
	);

	logic [63:0] s2;
	logic [63:0] es2;
	logic [F:0]  w_s;

	g2e_mul #(.SHIFT(F), .SIGNED(1'b1)) u_s2 (
		.clk (clk), .en (en), .a (slat), .b (slat), .p (s2)
	);
	g2e_mul #(.SHIFT(48), .SIGNED(1'b0)) u_es2 (
		.clk (clk), .en (en), .a ({16'd0, ecc}), .b (s2), .p (es2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s <= (es2 >= ONE) ? (F+1)'(1) : (F+1)'(ONE - es2);
		end
	end

	logic [NB+2:0]   sq_rem_s  [0:F];
	logic [NB-1:0]   sq_root_s [0:F];
	logic [2*NB-1:0] sq_num_s  [0:F];

	for (genvar k = 0; k <= F; k++) begin : g_sqrt
		logic [NB+2:0]   rem_in;
		logic [NB-1:0]   root_in;
		logic [2*NB-1:0] num_in;
		logic [NB+2:0]   rem_sh;
		logic [NB+2:0]   trial;
		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign num_in  = {1'b0, w_s, {F{1'b0}}};
		end else begin : g_next
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign num_in  = sq_num_s[k-1];
		end
		assign rem_sh = {rem_in[NB:0], num_in[2*NB-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= trial) begin
					sq_rem_s[k]  <= rem_sh - trial;
					sq_root_s[k] <= {root_in[NB-2:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= rem_sh;
					sq_root_s[k] <= {root_in[NB-2:0], 1'b0};
				end
				sq_num_s[k] <= {num_in[2*NB-3:0], 2'b00};
			end
		end
	end

	logic [NW-1:0]   dv_num;
	logic [NW-58:0]  dv_hi;
	logic            dv_over;
	logic [NB-1:0]   dv_rem_s  [0:QB];
	logic [QB-1:0]   dv_quo_s  [0:QB];
	logic [QB-1:0]   dv_low_s  [0:QB];
	logic [NB-1:0]   dv_den_s  [0:QB];
	logic            dv_over_s [0:QB];
	logic [63:0]     radius_s;

	assign dv_num  = {{(F+16){1'b0}}, a_axis} << (F + 16);
	assign dv_hi   = dv_num[NW-1:QB];
	assign dv_over = ({8'd0, dv_hi} >= sq_root_s[F]);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0]  <= {8'd0, dv_hi};
			dv_quo_s[0]  <= '0;
			dv_low_s[0]  <= dv_num[QB-1:0];
			dv_den_s[0]  <= sq_root_s[F];
			dv_over_s[0] <= dv_over;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [NB:0] rem2;
		logic        take;
		assign rem2 = {dv_rem_s[k-1], dv_low_s[k-1][QB-1]};
		assign take = (rem2 >= {1'b0, dv_den_s[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k]  <= take ? NB'(rem2 - {1'b0, dv_den_s[k-1]}) : rem2[NB-1:0];
				dv_quo_s[k]  <= {dv_quo_s[k-1][QB-2:0], take};
				dv_low_s[k]  <= {dv_low_s[k-1][QB-2:0], 1'b0};
				dv_den_s[k]  <= dv_den_s[k-1];
				dv_over_s[k] <= dv_over_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_over_s[QB] || (dv_quo_s[QB] > (QB'(1) << (QB - 1)))) begin
				radius_s <= 64'd1 << (QB - 1);
			end else begin
				radius_s <= {{(64-QB){1'b0}}, dv_quo_s[QB]};
			end
		end
	end

	logic [37:0]  alt_a;
	logic [37:0]  alt_b;
	logic [63:0]  altq_a;
	logic [63:0]  altq_b;
	logic [63:0]  rxy_s;
	logic [63:0]  rzp;
	logic [63:0]  rz_s;
	logic [63:0]  clat_d;
	logic [191:0] trig_d;
	logic [63:0]  tp;
	logic [63:0]  xp;
	logic [63:0]  yp;
	logic [63:0]  zp;
	logic [37:0]  x_q;
	logic [37:0]  y_q;
	logic [37:0]  z_q;

	g2e_dly #(.W(38), .N(D)) u_alt_a (
		.clk (clk), .en (en), .d (item_s0.altitude), .q (alt_a)
	);
	g2e_dly #(.W(38), .N(2)) u_alt_b (
		.clk (clk), .en (en), .d (alt_a), .q (alt_b)
	);
	g2e_dly #(.W(64), .N(D + 1 - C)) u_clat (
		.clk (clk), .en (en), .d (clat), .q (clat_d)
	);
	g2e_dly #(.W(192), .N(D + 3 - C)) u_trig (
		.clk (clk), .en (en), .d ({clon, slon, slat}), .q (trig_d)
	);

	assign altq_a = {{26{alt_a[37]}}, alt_a} << RADIUS_FRAC;
	assign altq_b = {{26{alt_b[37]}}, alt_b} << RADIUS_FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			rxy_s <= radius_s + altq_a;
			rz_s  <= rzp + altq_b;
		end
	end

	g2e_mul #(.SHIFT(48), .SIGNED(1'b0)) u_rz (
		.clk (clk), .en (en), .a (radius_s), .b ((64'd1 << 48) - {16'd0, ecc}), .p (rzp)
	);
	g2e_mul #(.SHIFT(F), .SIGNED(1'b1)) u_t (
		.clk (clk), .en (en), .a (rxy_s), .b (clat_d), .p (tp)
	);
	g2e_mul #(.SHIFT(F + RADIUS_FRAC), .SIGNED(1'b1)) u_x (
		.clk (clk), .en (en), .a (tp), .b (trig_d[191:128]), .p (xp)
	);
	g2e_mul #(.SHIFT(F + RADIUS_FRAC), .SIGNED(1'b1)) u_y (
		.clk (clk), .en (en), .a (tp), .b (trig_d[127:64]), .p (yp)
	);
	g2e_mul #(.SHIFT(F + RADIUS_FRAC), .SIGNED(1'b1)) u_z (
		.clk (clk), .en (en), .a (rz_s), .b (trig_d[63:0]), .p (zp)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= saturate(xp);
			y_q <= saturate(yp);
			z_q <= saturate(zp);
		end
	end

	assign out_valid = vld_q[LAST];
	assign ecef_x    = x_q;
	assign ecef_y    = y_q;
	assign ecef_z    = z_q;
endmodule

`default_nettype wire

// File: src/geodetic_to_ecef.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// Converts geodetic points (binary-angle latitude and longitude, altitude in
// millimeters) to earth-centred X, Y, Z in millimeters on a programmable
// ellipsoid. The block takes one point per clock while in_stall is low and
// returns one result per point, in order. The path from acceptance to result
// runs through the CORDIC stages, one stage per root bit of the square root
// and 57 divide stages. A write of inverse_flattening starts an eccentricity
// update, during which cfg_ready is low and the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module geodetic_to_ecef #(
	parameter int CORDIC_STEPS  = 32,
	parameter int FRACTION_BITS = 48
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [31:0]                  latitude,
	input  wire logic signed [31:0]                  longitude,
	input  wire logic signed [37:0]                  altitude,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [37:0]                       ecef_x,
	output logic signed [37:0]                       ecef_y,
	output logic signed [37:0]                       ecef_z,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [g2e_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [g2e_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import g2e_pkg::*;

	logic        cfg_wr;
	logic [33:0] a_axis_q;
	logic        ecc_start;
	logic        ecc_busy;
	logic [47:0] ecc;
	logic        pop;
	logic        avail;
	g2e_item_t   item;

	assign cfg_ready = !ecc_busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign ecc_start = cfg_wr && (cfg_index == REG_INV_FLAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_axis_q <= SEMI_MAJOR_RESET;
		end else if (cfg_wr && (cfg_index == REG_SEMI_MAJOR)) begin
			a_axis_q <= cfg_data[33:0];
		end
	end

	g2e_ecc u_ecc (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ecc_start),
		.inv_data (cfg_data),
		.busy     (ecc_busy),
		.ecc      (ecc)
	);

	g2e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.latitude  (latitude),
		.longitude (longitude),
		.altitude  (altitude),
		.hold      (ecc_busy),
		.pop       (pop),
		.avail     (avail),
		.item      (item)
	);

	g2e_back #(.STEPS(CORDIC_STEPS), .F(FRACTION_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.item      (item),
		.a_axis    (a_axis_q),
		.ecc       (ecc),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.ecef_x    (ecef_x),
		.ecef_y    (ecef_y),
		.ecef_z    (ecef_z)
	);
endmodule

`default_nettype wire
